@@ design/sct_pkg.sv @@
// Shared types and constants for the source character tokenizer.
// Used by every module in the design folder; no dependencies.
package sct_pkg;

   localparam int LineBitsDefault = 16;
   localparam int ColBitsDefault  = 12;
   localparam int LenBitsDefault  = 12;
   localparam int QueueDepth      = 4;

   localparam logic [63:0] MaskLowReset  = 64'd8935422457074941952;
   localparam logic [63:0] MaskHighReset = 64'd8646911286296182784;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'd0,
      MODE_OP    = 4'd1,
      MODE_LCOM  = 4'd2,
      MODE_BCOM  = 4'd3,
      MODE_CHAR  = 4'd4,
      MODE_STR   = 4'd5,
      MODE_INT   = 4'd6,
      MODE_FLT   = 4'd7,
      MODE_IDENT = 4'd8
   } mode_type;

   typedef enum logic [2:0] {
      KIND_COMMENT = 3'd0,
      KIND_SYMBOL  = 3'd1,
      KIND_CHAR    = 3'd2,
      KIND_STRING  = 3'd3,
      KIND_INT     = 3'd4,
      KIND_FLOAT   = 3'd5,
      KIND_IDENT   = 3'd6,
      KIND_ERROR   = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_TOO_LONG = 2'd1,
      ERR_BAD_LEN  = 2'd2,
      ERR_INVALID  = 2'd3
   } err_type;

   localparam logic [0:0] CFG_MASK_LOW  = 1'b0;
   localparam logic [0:0] CFG_MASK_HIGH = 1'b1;

   // Character classes found by the front end
   typedef struct packed {
      logic sym;
      logic op;
      logic digit;
      logic alpha;
      logic space;
   } cls_type;

   function automatic logic is_op(input logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
             c == ">" || c == "=" || c == "<" || c == "!" || c == "&" || c == "|";
   endfunction

   function automatic logic pairs_with(input logic [7:0] op, input logic [7:0] c);
      logic r;
      case (op)
         "+", "%", "=", "!", "-", "/": r = (c == "=");
         "*": r = (c == "=") || (c == "*");
         ">": r = (c == "=") || (c == ">");
         "<": r = (c == "=") || (c == "<");
         "&": r = (c == "&");
         "|": r = (c == "|");
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

@@ design/sct_front.sv @@
// Front end: accepts requests, classifies each character and tracks position.
// Depends on sct_pkg.
module sct_front #(
   parameter int LINE_BITS = sct_pkg::LineBitsDefault,
   parameter int COL_BITS  = sct_pkg::ColBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [63:0]           csr_wdata,
   input  logic                  in_valid,
   input  logic [7:0]            in_char,
   input  logic                  in_eol,
   output logic                  in_ready,
   output logic                  q_push,
   output logic [7:0]            q_char,
   output logic                  q_eol,
   output sct_pkg::cls_type      q_cls,
   output logic [LINE_BITS-1:0]  q_line,
   output logic [COL_BITS-1:0]   q_col,
   input  logic                  q_full
);
   import sct_pkg::*;

   logic [63:0]          mask_lo_ff, mask_hi_ff;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic                 take;

   assign in_ready = !q_full;
   assign take     = in_valid && in_ready;
   assign q_push   = take;
   assign q_char   = in_char;
   assign q_eol    = in_eol;
   assign q_line   = line_ff;
   assign q_col    = col_ff;

   always_comb begin
      q_cls.sym   = in_char[7] ? 1'b0 :
                    (in_char[6] ? mask_hi_ff[in_char[5:0]] : mask_lo_ff[in_char[5:0]]);
      q_cls.op    = is_op(in_char);
      q_cls.digit = in_char >= "0" && in_char <= "9";
      q_cls.alpha = (in_char >= "a" && in_char <= "z") || (in_char >= "A" && in_char <= "Z");
      q_cls.space = in_char == " " || in_char == 8'd9 || in_char == 8'd10 ||
                    in_char == 8'd13 || in_char == 8'd0 || in_char == 8'd11 ||
                    in_char == 8'd12;
      line_in = line_ff;
      col_in  = col_ff;
      if (take) begin
         if (in_eol) begin
            if (line_ff != {LINE_BITS{1'b1}}) line_in = line_ff + 1'b1;
            col_in = '0;
         end else if (col_ff != {COL_BITS{1'b1}}) begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_lo_ff <= MaskLowReset;
         mask_hi_ff <= MaskHighReset;
         line_ff    <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         col_ff     <= '0;
      end else begin
         if (csr_we && csr_index == CFG_MASK_LOW)  mask_lo_ff <= csr_wdata;
         if (csr_we && csr_index == CFG_MASK_HIGH) mask_hi_ff <= csr_wdata;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end
endmodule

@@ design/sct_queue.sv @@
// Short FIFO between the front end and the lexer back end.
// Depends on sct_pkg.
module sct_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   import sct_pkg::*;
   localparam int AW = $clog2(QueueDepth);

   logic [WIDTH-1:0] mem_ff [QueueDepth];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;

   assign full      = cnt_ff == (AW+1)'(QueueDepth);
   assign not_empty = cnt_ff != '0;
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

@@ design/sct_back.sv @@
// Back end: lexer state machine, emits up to two token records per character
// through a two-entry output buffer. Depends on sct_pkg.
module sct_back #(
   parameter int LINE_BITS = sct_pkg::LineBitsDefault,
   parameter int COL_BITS  = sct_pkg::ColBitsDefault,
   parameter int LEN_BITS  = sct_pkg::LenBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  logic [7:0]           q_char,
   input  logic                 q_eol,
   input  sct_pkg::cls_type     q_cls,
   input  logic [LINE_BITS-1:0] q_line,
   input  logic [COL_BITS-1:0]  q_col,
   output logic                 q_pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [2:0]           out_kind,
   output logic [7:0]           out_first,
   output logic [7:0]           out_second,
   output logic [LINE_BITS-1:0] out_line,
   output logic [COL_BITS-1:0]  out_col,
   output logic [LEN_BITS-1:0]  out_len,
   output logic [1:0]           out_err,
   output logic                 out_last
);
   import sct_pkg::*;

   typedef struct packed {
      logic [2:0]           kind;
      logic [7:0]           first;
      logic [7:0]           second;
      logic [LINE_BITS-1:0] line;
      logic [COL_BITS-1:0]  col;
      logic [LEN_BITS-1:0]  len;
      logic [1:0]           err;
      logic                 last;
   } rec_type;

   localparam logic [LEN_BITS-1:0] LenTop = {LEN_BITS{1'b1}};

   mode_type             mode_ff, mode_in;
   logic [7:0]           prev_ff, prev_in, op_ff, op_in, fc_ff, fc_in;
   logic [LINE_BITS-1:0] sl_ff, sl_in;
   logic [COL_BITS-1:0]  sc_ff, sc_in;
   logic [LEN_BITS-1:0]  len_ff, len_in, grown;
   rec_type              buf_ff [2];
   rec_type              buf_in [2];
   logic [1:0]           cnt_ff, cnt_in;
   rec_type              r [3];
   logic [1:0]           n;
   logic                 scan, pop;

   function automatic rec_type mk(input kind_type k, input logic [7:0] f,
                                  input logic [7:0] s, input logic [LINE_BITS-1:0] l,
                                  input logic [COL_BITS-1:0] c,
                                  input logic [LEN_BITS-1:0] ln, input err_type e);
      rec_type t;
      t.kind = k; t.first = f; t.second = s;
      t.line = l; t.col = c; t.len = ln; t.err = e; t.last = 1'b0;
      return t;
   endfunction

   // A new character is taken when the buffer will have room for two records
   assign pop   = out_valid && out_ready;
   assign q_pop = q_valid && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop));
   assign grown = (len_ff != LenTop) ? len_ff + 1'b1 : len_ff;

   always_comb begin
      mode_in = mode_ff; prev_in = prev_ff; op_in = op_ff; fc_in = fc_ff;
      sl_in = sl_ff; sc_in = sc_ff; len_in = len_ff;
      scan = 1'b0; n = 2'd0;
      r[0] = '0; r[1] = '0; r[2] = '0;
      if (q_pop) begin
         prev_in = q_char;
         case (mode_ff)
            MODE_BCOM: begin
               len_in = grown;
               if (prev_ff == "*" && q_char == "/" && len_ff >= LEN_BITS'(3)) begin
                  r[n] = mk(KIND_COMMENT, fc_ff, 8'd0, sl_ff, sc_ff, grown, ERR_NONE);
                  n = n + 1'b1; mode_in = MODE_IDLE;
               end
            end
            MODE_LCOM: begin
               if (q_char == 8'd10) begin
                  r[n] = mk(KIND_COMMENT, fc_ff, 8'd0, sl_ff, sc_ff, len_ff, ERR_NONE);
                  n = n + 1'b1; mode_in = MODE_IDLE;
               end else len_in = grown;
            end
            MODE_OP: begin
               mode_in = MODE_IDLE; op_in = 8'd0;
               if (op_ff == "-" && q_cls.digit) begin
                  mode_in = MODE_INT; len_in = LEN_BITS'(2); fc_in = "-";
               end else if (op_ff == "/" && (q_char == "/" || q_char == "*")) begin
                  mode_in = (q_char == "/") ? MODE_LCOM : MODE_BCOM;
                  len_in = LEN_BITS'(2); fc_in = "/";
               end else if (pairs_with(op_ff, q_char)) begin
                  r[n] = mk(KIND_SYMBOL, op_ff, q_char, sl_ff, sc_ff, LEN_BITS'(2),
                            ERR_NONE);
                  n = n + 1'b1;
               end else begin
                  r[n] = mk(KIND_SYMBOL, op_ff, 8'd0, sl_ff, sc_ff, LEN_BITS'(1),
                            ERR_NONE);
                  n = n + 1'b1; scan = 1'b1;
               end
            end
            MODE_CHAR: begin
               if (q_char != "'") begin
                  if (len_ff == '0) begin
                     len_in = LEN_BITS'(1); fc_in = q_char; sl_in = q_line; sc_in = q_col;
                  end else begin
                     r[n] = mk(KIND_ERROR, q_char, 8'd0, q_line, q_col, LEN_BITS'(1),
                               ERR_TOO_LONG);
                     n = n + 1'b1;
                  end
               end else if (len_ff == LEN_BITS'(1)) begin
                  r[n] = mk(KIND_CHAR, fc_ff, 8'd0, sl_ff, sc_ff, len_ff, ERR_NONE);
                  n = n + 1'b1; mode_in = MODE_IDLE;
               end else begin
                  r[n] = mk(KIND_ERROR, q_char, 8'd0, q_line, q_col, LEN_BITS'(1),
                            ERR_BAD_LEN);
                  n = n + 1'b1;
               end
            end
            MODE_STR: begin
               if (q_char == "\"") begin
                  r[n] = mk(KIND_STRING, fc_ff, 8'd0, sl_ff, sc_ff, len_ff, ERR_NONE);
                  n = n + 1'b1; mode_in = MODE_IDLE;
               end else begin
                  if (len_ff == '0) fc_in = q_char;
                  len_in = grown;
               end
            end
            MODE_INT: begin
               if (q_cls.digit) len_in = grown;
               else if (q_char == ".") begin
                  len_in = grown; mode_in = MODE_FLT;
               end else begin
                  r[n] = mk(KIND_INT, fc_ff, 8'd0, sl_ff, sc_ff, len_ff, ERR_NONE);
                  n = n + 1'b1; mode_in = MODE_IDLE; scan = 1'b1;
               end
            end
            MODE_FLT: begin
               if (q_cls.digit) len_in = grown;
               else begin
                  r[n] = mk(KIND_FLOAT, fc_ff, 8'd0, sl_ff, sc_ff, len_ff, ERR_NONE);
                  n = n + 1'b1; mode_in = MODE_IDLE; scan = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (q_cls.alpha || q_cls.digit || q_char == "_") len_in = grown;
               else begin
                  r[n] = mk(KIND_IDENT, fc_ff, 8'd0, sl_ff, sc_ff, len_ff, ERR_NONE);
                  n = n + 1'b1; mode_in = MODE_IDLE; scan = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE; scan = 1'b1;
            end
         endcase

         if (scan) begin
            if (q_cls.sym) begin
               if (q_cls.op) begin
                  mode_in = MODE_OP; op_in = q_char; sl_in = q_line; sc_in = q_col;
               end else begin
                  r[n] = mk(KIND_SYMBOL, q_char, 8'd0, q_line, q_col, LEN_BITS'(1),
                            ERR_NONE);
                  n = n + 1'b1;
               end
            end else if (q_char == "'") begin
               mode_in = MODE_CHAR; len_in = '0; fc_in = 8'd0;
               sl_in = q_line; sc_in = q_col;
            end else if (q_char == "\"") begin
               mode_in = MODE_STR; len_in = '0; fc_in = 8'd0; sl_in = q_line;
               sc_in = (q_col != {COL_BITS{1'b1}}) ? q_col + 1'b1 : q_col;
            end else if (q_cls.digit || q_char == "#" || q_cls.alpha || q_char == "_") begin
               mode_in = q_cls.digit ? MODE_INT : (q_char == "#") ? MODE_LCOM : MODE_IDENT;
               len_in = LEN_BITS'(1); fc_in = q_char; sl_in = q_line; sc_in = q_col;
            end else if (!q_cls.space) begin
               r[n] = mk(KIND_ERROR, q_char, 8'd0, q_line, q_col, LEN_BITS'(1),
                         ERR_INVALID);
               n = n + 1'b1;
            end
         end

         if (mode_in == MODE_LCOM && q_eol) begin
            r[n] = mk(KIND_COMMENT, fc_in, 8'd0, sl_in, sc_in, len_in, ERR_NONE);
            n = n + 1'b1; mode_in = MODE_IDLE;
         end
         if (n != 2'd0) r[n - 1'b1].last = 1'b1;
      end
   end

   // Output buffer: drop the head on a pop, then append this character's records
   always_comb begin
      buf_in[0] = buf_ff[0];
      buf_in[1] = buf_ff[1];
      cnt_in    = cnt_ff;
      if (pop) begin
         buf_in[0] = buf_ff[1];
         cnt_in    = cnt_ff - 1'b1;
      end
      if (n != 2'd0) begin
         buf_in[cnt_in[0]] = r[0];
         if (n == 2'd2) buf_in[1] = r[1];
         cnt_in = cnt_in + n;
      end
   end

   assign out_valid  = cnt_ff != 2'd0;
   assign out_kind   = buf_ff[0].kind;
   assign out_first  = buf_ff[0].first;
   assign out_second = buf_ff[0].second;
   assign out_line   = buf_ff[0].line;
   assign out_col    = buf_ff[0].col;
   assign out_len    = buf_ff[0].len;
   assign out_err    = buf_ff[0].err;
   assign out_last   = buf_ff[0].last;

   always_ff @(posedge clock) begin
      buf_ff[0] <= buf_in[0];
      buf_ff[1] <= buf_in[1];
      if (reset) begin
         mode_ff <= MODE_IDLE;
         prev_ff <= " ";
         op_ff   <= 8'd0;
         fc_ff   <= 8'd0;
         sl_ff   <= '0;
         sc_ff   <= '0;
         len_ff  <= '0;
         cnt_ff  <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         prev_ff <= prev_in;
         op_ff   <= op_in;
         fc_ff   <= fc_in;
         sl_ff   <= sl_in;
         sc_ff   <= sc_in;
         len_ff  <= len_in;
         cnt_ff  <= cnt_in;
      end
   end
endmodule

@@ design/source_char_tokenizer.sv @@
// Top level of the source character tokenizer: front end, queue and lexer
// back end. Depends on sct_pkg, sct_front, sct_queue and sct_back.
//
//  channel | direction | payload
//  req_    | in        | tdata: char_code[7:0]; tlast: last_in_line
//  rsp_    | out       | tuser: token_kind; tdata: token fields; tlast: last_of_run
//  csr_    | in        | we, index, 64-bit mask data
//
// One request per cycle is taken while the four-entry queue has room.
// A record is offered once its request has passed the queue and been registered in
// the output buffer; a second record from the same request follows the first and
// holds the back end until the first has been accepted.
// Reset is synchronous; it restores the symbol masks, position and lexer mode.
// The queue holds requests while the two-record output buffer waits on rsp_tready.
module source_char_tokenizer #(
   parameter int LINE_BITS = sct_pkg::LineBitsDefault,
   parameter int COL_BITS  = sct_pkg::ColBitsDefault,
   parameter int LEN_BITS  = sct_pkg::LenBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // char_code
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // first_char, second_char, start_line, start_column, token_length,
   // error_code, zeros (64 bits at the default widths)
   output logic [((18 + LINE_BITS + COL_BITS + LEN_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,  // token_kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   import sct_pkg::*;

   localparam int QW = 8 + 1 + $bits(cls_type) + LINE_BITS + COL_BITS;
   localparam int TW = ((18 + LINE_BITS + COL_BITS + LEN_BITS + 7) / 8) * 8;

   logic                 f_push, f_full, q_ne, q_pop, f_eol;
   logic [7:0]           f_char;
   cls_type              f_cls;
   logic [LINE_BITS-1:0] f_line;
   logic [COL_BITS-1:0]  f_col;
   logic [QW-1:0]        q_out;
   logic [7:0]           fch, sch;
   logic [LINE_BITS-1:0] ln;
   logic [COL_BITS-1:0]  cl;
   logic [LEN_BITS-1:0]  len;
   logic [1:0]           err;

   sct_front #(.LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS)) u_front (
      .clock, .reset, .csr_we, .csr_index(csr_index), .csr_wdata,
      .in_valid(req_tvalid), .in_char(req_tdata), .in_eol(req_tlast),
      .in_ready(req_tready), .q_push(f_push), .q_char(f_char), .q_eol(f_eol),
      .q_cls(f_cls), .q_line(f_line), .q_col(f_col), .q_full(f_full)
   );

   sct_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .push(f_push),
      .push_data({f_char, f_eol, f_cls, f_line, f_col}), .full(f_full),
      .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
   );

   sct_back #(.LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS), .LEN_BITS(LEN_BITS)) u_back (
      .clock, .reset, .q_valid(q_ne),
      .q_char(q_out[QW-1 -: 8]), .q_eol(q_out[QW-9]),
      .q_cls(q_out[QW-10 -: $bits(cls_type)]),
      .q_line(q_out[COL_BITS +: LINE_BITS]), .q_col(q_out[COL_BITS-1:0]),
      .q_pop(q_pop), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_kind(rsp_tuser), .out_first(fch), .out_second(sch), .out_line(ln),
      .out_col(cl), .out_len(len), .out_err(err), .out_last(rsp_tlast)
   );

   assign rsp_tdata = TW'({err, len, cl, ln, sch, fch});
endmodule

@@ verif/source_char_tokenizer_test.sv @@
// Self-checking bench for source_char_tokenizer: character streams in, token records out.
// Depends on sct_pkg and the design sources only; the lexer is predicted inside the bench.
module source_char_tokenizer_test;
   import sct_pkg::*;

   localparam int CycleLimit = 2000000;
   localparam int DrainCycles = 12;

   typedef struct {
      logic [7:0] ch;
      logic       eol;
   } char_req_type;

   typedef struct {
      kind_type    kind;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic [15:0] ln;
      logic [11:0] cl;
      logic [11:0] len;
      err_type     err;
      logic        last;
   } token_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = CFG_MASK_LOW;
   logic [63:0] csr_wdata = 64'd0;

   source_char_tokenizer dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   char_req_type  pending_chars[$];
   token_rec_type expected_tokens[$];
   char_req_type  on_bus;
   logic     req_taken = 1'b0;
   logic     want_long_hold = 1'b0;
   logic     hold_started = 1'b0;
   int       hold_cnt = 0;
   int       burst_left = 0;
   int       gap_left = 0;
   int       fail_count = 0;
   int       chars_in = 0;
   int       tokens_out = 0;
   int       cycles = 0;
   int       kind_seen[8];

   // lexer state as predicted
   mode_type    lx_mode;
   logic [7:0]  prev_ch, pend_op, tok_first;
   logic [15:0] tok_line, cur_line;
   logic [11:0] tok_col, tok_len, cur_col;
   logic [63:0] mask_lo = MaskLowReset, mask_hi = MaskHighReset;

   function automatic logic sym_char(input logic [7:0] c);
      if (c < 8'd64) return mask_lo[c[5:0]];
      if (c < 8'd128) return mask_hi[c[5:0]];
      return 1'b0;
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic letter_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic blank_char(input logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h00 ||
             c == 8'h0b || c == 8'h0c;
   endfunction

   function automatic logic operator_char(input logic [7:0] c);
      case (c)
         "+", "-", "*", "/", "%", ">", "=", "<", "!", "&", "|": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic joins(input logic [7:0] op, input logic [7:0] c);
      case (op)
         "+", "%", "=", "!", "-", "/": return c == "=";
         "*": return c == "=" || c == "*";
         ">": return c == "=" || c == ">";
         "<": return c == "=" || c == "<";
         "&": return c == "&";
         "|": return c == "|";
         default: return 1'b0;
      endcase
   endfunction

   function automatic token_rec_type mk(input kind_type k, input logic [7:0] a,
                                        input logic [7:0] b,
                                        input logic [15:0] ln, input logic [11:0] cl,
                                        input logic [11:0] len, input err_type e);
      token_rec_type r;
      r.kind = k; r.c1 = a; r.c2 = b; r.ln = ln; r.cl = cl; r.len = len; r.err = e;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic token_rec_type open_token(input kind_type k);
      return mk(k, tok_first, 8'd0, tok_line, tok_col, tok_len, ERR_NONE);
   endfunction

   task automatic reset_lexer();
      lx_mode = MODE_IDLE; prev_ch = " "; pend_op = 8'd0; tok_first = 8'd0;
      tok_line = 16'd0; tok_col = 12'd0; tok_len = 12'd0;
      cur_line = 16'd1; cur_col = 12'd0;
   endtask

   task automatic grow();
      if (tok_len != 12'hFFF) tok_len++;
   endtask

   // Advance the lexer by one character and queue the records it yields
   task automatic lex_char(input logic [7:0] c, input logic eol);
      token_rec_type out[2];
      int          n;
      logic        scan, close;
      logic [7:0]  p, op;
      logic [15:0] ln;
      logic [11:0] cl;
      n = 0; scan = 1'b0; p = prev_ch; ln = cur_line; cl = cur_col;
      prev_ch = c;
      case (lx_mode)
         MODE_BCOM: begin
            close = p == "*" && c == "/" && tok_len >= 12'd3;
            grow();
            if (close) begin
               out[n] = open_token(KIND_COMMENT); n++; lx_mode = MODE_IDLE;
            end
         end
         MODE_LCOM: begin
            if (c == 8'h0a) begin
               out[n] = open_token(KIND_COMMENT); n++; lx_mode = MODE_IDLE;
            end else grow();
         end
         MODE_OP: begin
            op = pend_op; lx_mode = MODE_IDLE; pend_op = 8'd0;
            if (op == "-" && digit_char(c)) begin
               lx_mode = MODE_INT; tok_len = 12'd2; tok_first = "-";
            end else if (op == "/" && (c == "/" || c == "*")) begin
               lx_mode = (c == "/") ? MODE_LCOM : MODE_BCOM;
               tok_len = 12'd2; tok_first = "/";
            end else if (joins(op, c)) begin
               out[n] = mk(KIND_SYMBOL, op, c, tok_line, tok_col, 12'd2, ERR_NONE); n++;
            end else begin
               out[n] = mk(KIND_SYMBOL, op, 8'd0, tok_line, tok_col, 12'd1, ERR_NONE); n++;
               scan = 1'b1;
            end
         end
         MODE_CHAR: begin
            if (c != "'") begin
               if (tok_len == 12'd0) begin
                  tok_len = 12'd1; tok_first = c; tok_line = ln; tok_col = cl;
               end else begin
                  out[n] = mk(KIND_ERROR, c, 8'd0, ln, cl, 12'd1, ERR_TOO_LONG); n++;
               end
            end else if (tok_len == 12'd1) begin
               out[n] = open_token(KIND_CHAR); n++; lx_mode = MODE_IDLE;
            end else begin
               out[n] = mk(KIND_ERROR, c, 8'd0, ln, cl, 12'd1, ERR_BAD_LEN); n++;
            end
         end
         MODE_STR: begin
            if (c == "\"") begin
               out[n] = open_token(KIND_STRING); n++; lx_mode = MODE_IDLE;
            end else begin
               if (tok_len == 12'd0) tok_first = c;
               grow();
            end
         end
         MODE_INT: begin
            if (digit_char(c)) grow();
            else if (c == ".") begin
               grow(); lx_mode = MODE_FLT;
            end else begin
               out[n] = open_token(KIND_INT); n++; lx_mode = MODE_IDLE; scan = 1'b1;
            end
         end
         MODE_FLT: begin
            if (digit_char(c)) grow();
            else begin
               out[n] = open_token(KIND_FLOAT); n++; lx_mode = MODE_IDLE; scan = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (letter_char(c) || digit_char(c) || c == "_") grow();
            else begin
               out[n] = open_token(KIND_IDENT); n++; lx_mode = MODE_IDLE; scan = 1'b1;
            end
         end
         default: begin
            lx_mode = MODE_IDLE; scan = 1'b1;
         end
      endcase

      if (scan) begin
         if (sym_char(c)) begin
            if (operator_char(c)) begin
               lx_mode = MODE_OP; pend_op = c; tok_line = ln; tok_col = cl;
            end else begin
               out[n] = mk(KIND_SYMBOL, c, 8'd0, ln, cl, 12'd1, ERR_NONE); n++;
            end
         end else if (c == "'") begin
            lx_mode = MODE_CHAR; tok_len = 12'd0; tok_first = 8'd0;
            tok_line = ln; tok_col = cl;
         end else if (c == "\"") begin
            lx_mode = MODE_STR; tok_len = 12'd0; tok_first = 8'd0;
            tok_line = ln; tok_col = (cl != 12'hFFF) ? cl + 12'd1 : cl;
         end else if (digit_char(c) || c == "#" || letter_char(c) || c == "_") begin
            lx_mode = digit_char(c) ? MODE_INT : (c == "#") ? MODE_LCOM : MODE_IDENT;
            tok_len = 12'd1; tok_first = c; tok_line = ln; tok_col = cl;
         end else if (!blank_char(c)) begin
            out[n] = mk(KIND_ERROR, c, 8'd0, ln, cl, 12'd1, ERR_INVALID); n++;
         end
      end

      if (lx_mode == MODE_LCOM && eol) begin
         out[n] = open_token(KIND_COMMENT); n++; lx_mode = MODE_IDLE;
      end

      if (eol) begin
         if (cur_line != 16'hFFFF) cur_line++;
         cur_col = 12'd0;
      end else if (cur_col != 12'hFFF) begin
         cur_col++;
      end

      if (n > 0) out[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_tokens = {expected_tokens, out[i]};
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
         fail_count++;
      end
   endtask

   // Responses first, then requests, then the limit
   always @(posedge clock) begin
      token_rec_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         tokens_out++;
         kind_seen[rsp_tuser]++;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected record, expected none, got %h %h", $time,
                     rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            e = expected_tokens.pop_front();
            check_field("token_kind", 16'(e.kind), 16'(rsp_tuser));
            check_field("first_char", 16'(e.c1), 16'(rsp_tdata[7:0]));
            check_field("second_char", 16'(e.c2), 16'(rsp_tdata[15:8]));
            check_field("start_line", e.ln, rsp_tdata[31:16]);
            check_field("start_column", 16'(e.cl), 16'(rsp_tdata[43:32]));
            check_field("token_length", 16'(e.len), 16'(rsp_tdata[55:44]));
            check_field("error_code", 16'(e.err), 16'(rsp_tdata[57:56]));
            check_field("padding", 16'd0, 16'(rsp_tdata[63:58]));
            check_field("last_of_run", 16'(e.last), 16'(rsp_tlast));
         end
      end
      req_taken <= 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         lex_char(req_tdata, req_tlast);
         chars_in++;
         req_taken <= 1'b1;
      end
      if (cycles > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Sender: bursts with gaps, holds the request until it is taken
   always @(negedge clock) begin
      if (reset || (req_tvalid && !req_taken)) begin
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
         on_bus = pending_chars.pop_front();
         req_tvalid <= 1'b1;
         req_tdata <= on_bus.ch;
         req_tlast <= on_bus.eol;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: its own stall pattern, plus one long hold-off
   always @(negedge clock) begin
      if (want_long_hold && !hold_started) begin
         hold_started <= 1'b1;
         hold_cnt <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= (hold_cnt == 1);
      end else if (reset) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ((cycles / 37) % 3 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   task automatic send_char(input logic [7:0] c, input logic eol);
      char_req_type r;
      r.ch = c; r.eol = eol;
      pending_chars = {pending_chars, r};
   endtask

   task automatic send_text(input string s, input logic eol_at_end);
      for (int i = 0; i < s.len(); i++) send_char(s[i], eol_at_end && i == s.len() - 1);
   endtask

   task automatic settle();
      wait (pending_chars.size() == 0 && !req_tvalid && expected_tokens.size() == 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_mask(input logic idx, input logic [63:0] value);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CFG_MASK_LOW) mask_lo = value;
      else mask_hi = value;
   endtask

   function automatic string rand_word(input int kind_sel);
      string s;
      int    n;
      s = "";
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         case (kind_sel)
            0: s = {s, string'(8'($urandom_range("0", "9")))};
            1: s = {s, string'(8'($urandom_range(" ", "~")))};
            default: s = {s, string'(8'($urandom_range(0, 2) == 0 ? "_" :
                          $urandom_range(0, 1) ? $urandom_range("a", "z") :
                          $urandom_range("A", "Z")))};
         endcase
      end
      return s;
   endfunction

   // Random tokens, some malformed (bad char literals, random bytes), with blanks between them
   task automatic random_phase(input int count);
      string ops[14] = '{"+=", "%=", "-=", "*=", "**", "/=", ">=", ">>", "<=", "<<",
                         "==", "!=", "&&", "||"};
      string t, body;
      int    start;
      start = pending_chars.size();
      while (pending_chars.size() - start < count) begin
         case ($urandom_range(0, 13))
            0, 1: t = rand_word(2);
            2: t = rand_word(0);
            3: t = {rand_word(0), ".", rand_word(0)};
            4: t = {"-", rand_word(0)};
            5: begin
               body = rand_word(1);
               for (int i = 0; i < body.len(); i++) if (body[i] == "\"") body[i] = "x";
               t = {"\"", body, "\""};
            end
            6: t = {"'", string'(8'($urandom_range(" ", "~"))), "'"};
            7: t = ops[$urandom_range(0, 13)];
            8: t = string'(8'($urandom_range(0, 1) ? "(" : ";"));
            9: t = {"// ", rand_word(1), "\n"};
            10: t = {"/* ", rand_word(1), " */"};
            11: t = {"# ", rand_word(2)};
            12: t = $urandom_range(0, 1) ? "''" : {"'", rand_word(2), "'"};
            default: t = string'(8'($urandom_range(0, 255)));
         endcase
         send_text(t, 1'b0);
         send_char($urandom_range(0, 3) ? " " : 8'h09, $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      reset_lexer();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: operators, comments, literals, numbers, invalid bytes
      send_text("a_1=-5>>=3.25!x", 1'b1);
      send_text("# c", 1'b1);
      send_text("/**/ //z", 1'b1);
      send_text("'a''''bc'\"\"\"hi\"", 1'b0);
      send_char(8'h80, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char("@", 1'b0);
      send_char("-", 1'b1);
      send_char("=", 1'b0);
      send_char(8'h00, 1'b1);
      settle();

      random_phase(150);
      want_long_hold = 1'b1;
      random_phase(40);
      settle();

      write_mask(CFG_MASK_LOW, {64{1'b1}});
      write_mask(CFG_MASK_HIGH, {64{1'b1}});
      random_phase(60);
      settle();

      write_mask(CFG_MASK_LOW, 64'd0);
      write_mask(CFG_MASK_HIGH, 64'd0);
      random_phase(60);
      settle();

      write_mask(CFG_MASK_LOW, {$urandom, $urandom});
      write_mask(CFG_MASK_HIGH, {$urandom, $urandom});
      random_phase(60);
      settle();

      write_mask(CFG_MASK_LOW, MaskLowReset);
      write_mask(CFG_MASK_HIGH, MaskHighReset);
      random_phase(40);
      settle();

      $display("Accepted %0d characters and checked %0d token records", chars_in, tokens_out);
      $display("Kinds seen: cmt %0d sym %0d chr %0d str %0d int %0d flt %0d id %0d err %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
               kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
